// File: rtl/pmpd_pkg.sv
// ----------------------------------------------------------------------------
// pmpd_pkg: shared types and constants of the ps/2 mouse packet decoder
// Field widths, packet bit positions, acceleration thresholds and codes.
// ----------------------------------------------------------------------------
package pmpd_pkg;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 13;
  localparam int CFG_IX_W = 2;
  localparam int OUT_CW   = 12;
  localparam int BTN_IX_W = 2;
  localparam int NBTN     = 3;

  // delta widths: 9-bit raw delta, up to three times that after the curve
  localparam int DELTA_W  = 9;
  localparam int ACC_W    = 11;

  // flag byte layout
  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;
  localparam logic [BYTE_W-1:0] OVF_MASK = 8'hC0;

  // acceleration thresholds on the delta magnitude
  localparam logic [DELTA_W-1:0] CURVE_TRIPLE = 9'd10;
  localparam logic [DELTA_W-1:0] CURVE_DOUBLE = 9'd5;

  // register reset values
  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

  // position of the next byte in the packet
  typedef enum logic [1:0] {
    POS_FLAG  = 2'd0,
    POS_XDATA = 2'd1,
    POS_YDATA = 2'd2
  } pos_t;

  // configuration register indexes
  typedef enum logic [CFG_IX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1
  } cfg_idx_t;

  // event kinds
  typedef enum logic {
    EV_MOVE   = 1'b0,
    EV_BUTTON = 1'b1
  } ev_kind_t;

endpackage

// File: rtl/ps2_mouse_packet_decoder_top.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder_top: ps/2 mouse three-byte packet decoder
// Assembles mouse bytes into packets, accelerates the deltas, tracks a
// clamped cursor and reports move and button change events.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one mouse byte per word. A first byte needs bit 3 set, others
//           are dropped until one does. Overflow packets are dropped whole.
//   out_* : event words. A completing byte gives zero to four events: one
//           move event if a delta is nonzero, then one per changed button,
//           lowest button first; out_last_event marks the final one.
//   cfg_* : writes screen_width (index 0) or screen_height (index 1) and
//           recenters the cursor; always ready. Other indexes are ignored.
// Timing
//   The packet is processed in the cycle its last byte is taken; its first
//   event is shown the next cycle and further events follow one per cycle
//   while the receiver is ready. The first two bytes of a packet are taken
//   every cycle, even while events of the previous packet are waiting. The
//   third byte waits until the pending events have drained.
// Reset
//   Synchronous, active low: sizes 640 x 480, cursor centered, buttons up.
//   A stalled receiver holds the current event word unchanged, except that a size write changes its cursor fields.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pmpd_pkg::BYTE_W-1:0]   in_data_byte,
  // event output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_event_kind,
  output logic [pmpd_pkg::BTN_IX_W-1:0] out_button_index,
  output logic                          out_pressed,
  output logic [pmpd_pkg::OUT_CW-1:0]   out_cursor_x_out,
  output logic [pmpd_pkg::OUT_CW-1:0]   out_cursor_y_out,
  output logic                          out_last_event,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmpd_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [pmpd_pkg::CFG_W-1:0]    cfg_data
);
  import pmpd_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int SZ_W  = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;
  localparam int SUM_W = ((CB > ACC_W) ? CB : ACC_W) + 2;

  // effective screen size: zero counts as one, capped at 2^CB
  function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SZ_W-1:0] ve;
    logic [SZ_W-1:0] lim;
    ve  = SZ_W'(v);
    lim = SZ_W'(1) << CB;
    if (v == '0) begin
      return SZ_W'(1);
    end else if (ve > lim) begin
      return lim;
    end
    return ve;
  endfunction

  function automatic logic [CB-1:0] max_coord(input logic [CFG_W-1:0] v);
    logic [SZ_W-1:0] e;
    e = eff_size(v) - SZ_W'(1);
    return e[CB-1:0];
  endfunction

  function automatic logic [CB-1:0] center(input logic [CFG_W-1:0] v);
    logic [SZ_W-1:0] e;
    e = eff_size(v) >> 1;
    return e[CB-1:0];
  endfunction

  // acceleration: above 10 tripled, above 5 doubled
  function automatic logic signed [ACC_W-1:0] curve(input logic [DELTA_W-1:0] d);
    logic signed [ACC_W-1:0] de;
    logic [DELTA_W-1:0]      mag;
    de  = {{(ACC_W-DELTA_W){d[DELTA_W-1]}}, d};
    mag = d[DELTA_W-1] ? (~d + DELTA_W'(1)) : d;
    if (mag > CURVE_TRIPLE) begin
      return de + (de <<< 1);
    end else if (mag > CURVE_DOUBLE) begin
      return de <<< 1;
    end
    return de;
  endfunction

  // clamp a signed sum into 0..hi
  function automatic logic [CB-1:0] clamp(input logic signed [SUM_W-1:0] s,
                                          input logic [CB-1:0] hi);
    logic signed [SUM_W-1:0] hs;
    hs = $signed({{(SUM_W-CB){1'b0}}, hi});
    if (s < 0) begin
      return '0;
    end else if (s > hs) begin
      return hi;
    end
    return s[CB-1:0];
  endfunction

  // registers
  pos_t              pos_r, pos_nxt;
  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [BYTE_W-1:0] xbyte_r, xbyte_nxt;
  logic [NBTN-1:0]   levels_r, levels_nxt;
  logic [CB-1:0]     cursor_x_r, cursor_x_nxt;
  logic [CB-1:0]     cursor_y_r, cursor_y_nxt;
  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic              mv_pend_r, mv_pend_nxt;
  logic [NBTN-1:0]   chg_pend_r, chg_pend_nxt;

  // handshakes
  logic in_fire;
  logic out_fire;
  logic cfg_fire;
  logic evt_pend;

  // packet datapath
  logic [DELTA_W-1:0]      dx;
  logic [DELTA_W-1:0]      dy;
  logic signed [ACC_W-1:0] ax;
  logic signed [ACC_W-1:0] ay;
  logic signed [SUM_W-1:0] sx;
  logic signed [SUM_W-1:0] sy;
  logic [NBTN-1:0]         btn_now;
  logic [NBTN-1:0]         btn_chg;
  logic                    pkt_done;
  logic                    pkt_ok;
  logic                    moved;

  // event selection
  logic [NBTN-1:0]     chg_low;
  logic [NBTN-1:0]     chg_rest;
  logic [BTN_IX_W-1:0] btn_ix;
  logic [CB+OUT_CW-1:0] cx_ext;
  logic [CB+OUT_CW-1:0] cy_ext;

  assign evt_pend = mv_pend_r | (|chg_pend_r);
  assign in_ready = (pos_r != POS_YDATA) || !evt_pend;
  assign cfg_ready = 1'b1;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;

  // packet position
  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      case (pos_r)
        POS_FLAG: begin
          if (in_data_byte[SYNC_BIT]) begin
            pos_nxt = POS_XDATA;
          end
        end
        POS_XDATA: pos_nxt = POS_YDATA;
        POS_YDATA: pos_nxt = POS_FLAG;
        default:   pos_nxt = POS_FLAG;
      endcase
    end
  end

  // deltas, acceleration and new cursor
  always_comb begin
    dx       = {flag_r[XSIGN_BIT], xbyte_r};
    dy       = {flag_r[YSIGN_BIT], in_data_byte};
    ax       = curve(dx);
    ay       = curve(dy);
    sx       = $signed({{(SUM_W-CB){1'b0}}, cursor_x_r})
               + $signed({{(SUM_W-ACC_W){ax[ACC_W-1]}}, ax});
    sy       = $signed({{(SUM_W-CB){1'b0}}, cursor_y_r})
               - $signed({{(SUM_W-ACC_W){ay[ACC_W-1]}}, ay});
    btn_now  = flag_r[NBTN-1:0];
    btn_chg  = btn_now ^ levels_r;
    pkt_done = in_fire && (pos_r == POS_YDATA);
    pkt_ok   = pkt_done && ((flag_r & OVF_MASK) == '0);
    moved    = (dx != '0) || (dy != '0);
  end

  // current event word
  always_comb begin
    chg_low  = chg_pend_r & (~chg_pend_r + NBTN'(1));
    chg_rest = chg_pend_r & ~chg_low;
    if (chg_pend_r[0]) begin
      btn_ix = BTN_IX_W'(0);
    end else if (chg_pend_r[1]) begin
      btn_ix = BTN_IX_W'(1);
    end else begin
      btn_ix = BTN_IX_W'(2);
    end
    cx_ext = {{OUT_CW{1'b0}}, cursor_x_r};
    cy_ext = {{OUT_CW{1'b0}}, cursor_y_r};
    out_valid        = evt_pend;
    out_event_kind   = mv_pend_r ? EV_MOVE : EV_BUTTON;
    out_button_index = mv_pend_r ? '0 : btn_ix;
    out_pressed      = mv_pend_r ? 1'b0 : levels_r[btn_ix];
    out_last_event   = mv_pend_r ? (chg_pend_r == '0) : (chg_rest == '0);
    out_cursor_x_out = cx_ext[OUT_CW-1:0];
    out_cursor_y_out = cy_ext[OUT_CW-1:0];
  end

  // next values of the state
  always_comb begin
    flag_nxt     = flag_r;
    xbyte_nxt    = xbyte_r;
    levels_nxt   = levels_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    mv_pend_nxt  = mv_pend_r;
    chg_pend_nxt = chg_pend_r;

    // drain one event
    if (out_fire) begin
      if (mv_pend_r) begin
        mv_pend_nxt = 1'b0;
      end else begin
        chg_pend_nxt = chg_rest;
      end
    end

    // capture bytes
    if (in_fire && (pos_r == POS_FLAG)) begin
      flag_nxt = in_data_byte;
    end
    if (in_fire && (pos_r == POS_XDATA)) begin
      xbyte_nxt = in_data_byte;
    end

    // complete packet
    if (pkt_ok) begin
      if (moved) begin
        cursor_x_nxt = clamp(sx, max_coord(width_r));
        cursor_y_nxt = clamp(sy, max_coord(height_r));
      end
      levels_nxt   = btn_now;
      mv_pend_nxt  = moved;
      chg_pend_nxt = btn_chg;
    end

    // size writes recenter the cursor
    if (cfg_fire) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH: begin
          width_nxt    = cfg_data;
          cursor_x_nxt = center(cfg_data);
          cursor_y_nxt = center(height_r);
        end
        CFG_SCREEN_HEIGHT: begin
          height_nxt   = cfg_data;
          cursor_x_nxt = center(width_r);
          cursor_y_nxt = center(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // control and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_FLAG;
      levels_r   <= '0;
      width_r    <= RST_WIDTH;
      height_r   <= RST_HEIGHT;
      cursor_x_r <= center(RST_WIDTH);
      cursor_y_r <= center(RST_HEIGHT);
      mv_pend_r  <= 1'b0;
      chg_pend_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      levels_r   <= levels_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      mv_pend_r  <= mv_pend_nxt;
      chg_pend_r <= chg_pend_nxt;
    end
  end

  // packet byte holding registers
  always_ff @(posedge clk) begin
    flag_r  <= flag_nxt;
    xbyte_r <= xbyte_nxt;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: ps/2 mouse packet decoder check
// Feeds directed and random mouse byte streams through the decoder under
// several screen sizes and idling patterns. A local packet decoder predicts
// every event word, and the monitor compares each received word, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import pmpd_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int DELTA_SPAN = 256;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  // register indexes past the last register; writes to them are ignored
  localparam logic [CFG_IX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    ev_kind_t             kind;
    logic [BTN_IX_W-1:0]  btn;
    logic                 pressed;
    logic [OUT_CW-1:0]    x;
    logic [OUT_CW-1:0]    y;
    logic                 last;
  } mouse_event_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_event_kind;
  logic [BTN_IX_W-1:0] out_button_index;
  logic                out_pressed;
  logic [OUT_CW-1:0]   out_cursor_x_out;
  logic [OUT_CW-1:0]   out_cursor_y_out;
  logic                out_last_event;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;

  // pending mouse bytes and predicted event words
  logic [BYTE_W-1:0] mouse_bytes [$];
  mouse_event_t      event_q [$];
  mouse_event_t      head_ev;
  int                fail_count = 0;

  // idling control
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  // local decoder state
  pos_t             pos;
  logic [BYTE_W-1:0] flag_reg;
  logic [BYTE_W-1:0] xdata_reg;
  logic [NBTN-1:0]   btn_levels;
  logic [CFG_W-1:0]  scr_w;
  logic [CFG_W-1:0]  scr_h;
  int                cur_x;
  int                cur_y;

  ps2_mouse_packet_decoder_top #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_button_index (out_button_index),
    .out_pressed      (out_pressed),
    .out_cursor_x_out (out_cursor_x_out),
    .out_cursor_y_out (out_cursor_y_out),
    .out_last_event   (out_last_event),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // size as the decoder sees it: zero counts as one, capped at the coordinate range
  function automatic int screen_span(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > (1 << COORD_BITS)) return 1 << COORD_BITS;
    return int'(v);
  endfunction

  function automatic void recenter();
    cur_x = screen_span(scr_w) / 2;
    cur_y = screen_span(scr_h) / 2;
  endfunction

  // acceleration curve on a signed delta
  function automatic int accel(input int d);
    int mag;
    mag = (d < 0) ? -d : d;
    if (mag > int'(CURVE_TRIPLE)) return d * 3;
    if (mag > int'(CURVE_DOUBLE)) return d * 2;
    return d;
  endfunction

  function automatic int clamp_coord(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // packet assembly and event prediction for one accepted byte
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    int           dx;
    int           dy;
    int           n;
    logic [NBTN-1:0] now_btn;
    logic [NBTN-1:0] changed;
    mouse_event_t evs [4];
    n = 0;
    case (pos)
      POS_FLAG: begin
        if (b[SYNC_BIT]) begin
          flag_reg = b;
          pos = POS_XDATA;
        end
      end
      POS_XDATA: begin
        xdata_reg = b;
        pos = POS_YDATA;
      end
      default: begin
        pos = POS_FLAG;
        if ((flag_reg & OVF_MASK) == '0) begin
          dx = int'(xdata_reg) - (flag_reg[XSIGN_BIT] ? DELTA_SPAN : 0);
          dy = int'(b) - (flag_reg[YSIGN_BIT] ? DELTA_SPAN : 0);
          if (dx != 0 || dy != 0) begin
            cur_x = clamp_coord(cur_x + accel(dx), screen_span(scr_w) - 1);
            cur_y = clamp_coord(cur_y - accel(dy), screen_span(scr_h) - 1);
            evs[n] = '{EV_MOVE, '0, 1'b0, cur_x[OUT_CW-1:0], cur_y[OUT_CW-1:0], 1'b0};
            n++;
          end
          now_btn = flag_reg[NBTN-1:0];
          changed = now_btn ^ btn_levels;
          btn_levels = now_btn;
          for (int i = 0; i < NBTN; i++) begin
            if (changed[i]) begin
              evs[n] = '{EV_BUTTON, BTN_IX_W'(i), now_btn[i],
                         cur_x[OUT_CW-1:0], cur_y[OUT_CW-1:0], 1'b0};
              n++;
            end
          end
          for (int k = 0; k < n; k++) begin
            evs[k].last = (k == n - 1);
            event_q.push_back(evs[k]);
          end
        end
      end
    endcase
  endfunction

  // driver: offers the next pending byte, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte);
      end
      if (!in_valid || in_ready) begin
        if (mouse_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= mouse_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_OFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: compares each event word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          $error("unexpected event word: kind %0d button %0d x %0d y %0d",
                 out_event_kind, out_button_index, out_cursor_x_out, out_cursor_y_out);
          fail_count++;
        end else begin
          head_ev = event_q.pop_front();
          check_field("event_kind", head_ev.kind, out_event_kind);
          check_field("button_index", head_ev.btn, out_button_index);
          check_field("pressed", head_ev.pressed, out_pressed);
          check_field("cursor_x_out", head_ev.x, out_cursor_x_out);
          check_field("cursor_y_out", head_ev.y, out_cursor_y_out);
          check_field("last_event", head_ev.last, out_last_event);
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // register write; the local copy follows at the handshake
  task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) begin
      scr_w = val;
      recenter();
    end else if (idx == CFG_SCREEN_HEIGHT) begin
      scr_h = val;
      recenter();
    end
  endtask

  // wait until every byte is taken and every event word has arrived
  task automatic wait_drained();
    while (mouse_bytes.size() > 0 || in_valid || event_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // delta byte: full range, zero, or small around the threshold points
  function automatic logic [BYTE_W-1:0] pick_delta(input logic neg);
    int mag;
    case ($urandom_range(3))
      0: return BYTE_W'($urandom);
      1: return '0;
      default: begin
        mag = $urandom_range(0, 12);
        return neg ? BYTE_W'(DELTA_SPAN - mag) : BYTE_W'(mag);
      end
    endcase
  endfunction

  // mostly well-formed packets, some overflow, some cut short, some noise
  task automatic queue_random_traffic(input int n_items);
    int              left;
    logic [BYTE_W-1:0] flags;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        mouse_bytes.push_back(BYTE_W'($urandom));
        left--;
      end else begin
        flags = BYTE_W'($urandom);
        flags[SYNC_BIT] = 1'b1;
        if ($urandom_range(7) != 0) flags = flags & ~OVF_MASK;
        mouse_bytes.push_back(flags);
        mouse_bytes.push_back(pick_delta(flags[XSIGN_BIT]));
        left -= 2;
        if ($urandom_range(15) != 0) begin
          mouse_bytes.push_back(pick_delta(flags[YSIGN_BIT]));
          left--;
        end
      end
    end
  endtask

  // stimulus sequence
  initial begin
    pos = POS_FLAG;
    flag_reg = '0;
    xdata_reg = '0;
    btn_levels = '0;
    scr_w = RST_WIDTH;
    scr_h = RST_HEIGHT;
    recenter();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset size
    mouse_bytes = '{
      8'h00, 8'hF7,               // out of sync, ignored
      8'h08, 8'h00, 8'h00,        // nothing to report
      8'h0F, 8'h05, 8'h06,        // all buttons down, deltas at the double threshold
      8'h08, 8'h0B, 8'h0A,        // all buttons up, deltas at the triple threshold
      8'h48, 8'h10, 8'h10,        // x overflow, dropped
      8'h88, 8'h10, 8'h10,        // y overflow, dropped
      8'h38, 8'h00, 8'h00,        // most negative deltas, clamped
      8'h09, 8'hFF, 8'hFF,        // largest positive deltas, clamped
      8'h3A, 8'hFA, 8'hF5         // small negative deltas, buttons swap
    };
    wait_drained();

    // largest width, zero height; no idling, then a long receiver hold-off
    write_reg(CFG_SCREEN_WIDTH, 13'h1FFF);
    write_reg(CFG_SCREEN_HEIGHT, 13'h0000);
    queue_random_traffic(62);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    wait_drained();

    // one pixel wide, full height; sender mostly idle
    write_reg(CFG_SCREEN_WIDTH, 13'd1);
    write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
    send_idle_pct <= 88;
    recv_stall_pct <= 0;
    queue_random_traffic(62);
    wait_drained();

    // just past the coordinate range, tiny height; receiver mostly stalled
    write_reg(CFG_SCREEN_WIDTH, 13'd4097);
    write_reg(CFG_SCREEN_HEIGHT, 13'd2);
    send_idle_pct <= 0;
    recv_stall_pct <= 88;
    queue_random_traffic(62);
    wait_drained();

    // random sizes, spare indexes ignored; both sides idling
    write_reg(CFG_SCREEN_WIDTH, CFG_W'($urandom_range(1, 4096)));
    write_reg(CFG_SCREEN_HEIGHT, CFG_W'($urandom_range(1, 4096)));
    write_reg(CFG_SPARE_A, CFG_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_W'($urandom));
    send_idle_pct <= 22;
    recv_stall_pct <= 22;
    queue_random_traffic(62);
    wait_drained();

    // zero width, largest height; no idling
    write_reg(CFG_SCREEN_WIDTH, 13'h0000);
    write_reg(CFG_SCREEN_HEIGHT, 13'h1FFF);
    send_idle_pct <= 0;
    recv_stall_pct <= 0;
    queue_random_traffic(62);
    wait_drained();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
